/* sv/wrdiv_pkg.sv */
// Shared constants and control types for the wide restoring divider.
`default_nettype none
package wrdiv_pkg;

  localparam int WORDS     = 6;
  localparam int WORD_BITS = 32;
  localparam int WIDE      = WORDS * WORD_BITS;
  localparam int CNT_W     = $clog2(WORDS + 1);
  localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W     = $clog2(WIDE);
  localparam int STEP_W    = $clog2(WIDE + 1);
  localparam int SHIFT     = $clog2(WORD_BITS);

  typedef struct packed {
    logic              load;
    logic              load_first;
    logic [WIDX_W-1:0] load_idx;
    logic              prep;
    logic              step;
    logic [IDX_W-1:0]  bit_idx;
    logic              emit;
  } dp_cmd_t;

  typedef struct packed {
    logic strobe;
    logic fin;
    logic zero;
  } out_stat_t;

endpackage
`default_nettype wire

/* sv/wrdiv_ctrl.sv */
// Controller state machine: operand loading, division steps and result beats.
`default_nettype none
module wrdiv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_word,
  input  logic                divisor_zero,
  output logic                busy,
  output wrdiv_pkg::dp_cmd_t  cmd,
  output wrdiv_pkg::out_stat_t ostat
);
  import wrdiv_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  outc_r, outc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              zero_r, zero_nxt;
  logic              room;

  assign room = cnt_r < CNT_W'(WORDS);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    outc_nxt  = outc_r;
    step_nxt  = step_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (room) begin
            cmd.load       = 1'b1;
            cmd.load_first = (cnt_r == '0);
            cmd.load_idx   = WIDX_W'(cnt_r);
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          if (last_word) begin
            n_nxt     = room ? cnt_r + CNT_W'(1) : cnt_r;
            cnt_nxt   = '0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        outc_nxt = '0;
        zero_nxt = divisor_zero;
        step_nxt = STEP_W'({n_r, {SHIFT{1'b0}}});
        state_nxt = divisor_zero ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.step    = 1'b1;
        cmd.bit_idx = IDX_W'(step_r - STEP_W'(1));
        step_nxt    = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.emit = 1'b1;
        outc_nxt = outc_r + CNT_W'(1);
        if (outc_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      outc_r  <= '0;
      step_r  <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      outc_r  <= outc_nxt;
      step_r  <= step_nxt;
      zero_r  <= zero_nxt;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign ostat.strobe = (state_r == ST_OUT);
  assign ostat.fin    = (state_r == ST_OUT) && (outc_r == n_r - CNT_W'(1));
  assign ostat.zero   = (state_r == ST_OUT) && zero_r;

endmodule
`default_nettype wire

/* sv/wrdiv_dp.sv */
// Datapath: operand registers, shift-subtract remainder unit and quotient shifter.
`default_nettype none
module wrdiv_dp (
  input  logic                          clk,
  input  wrdiv_pkg::dp_cmd_t            cmd,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] dividend_word,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] divisor_word,
  output logic                          divisor_zero,
  output logic [wrdiv_pkg::WORD_BITS-1:0] quo_word,
  output logic [wrdiv_pkg::WORD_BITS-1:0] rem_word
);
  import wrdiv_pkg::*;

  logic [WORDS-1:0][WORD_BITS-1:0] dvd_r, dvd_nxt;
  logic [WORDS-1:0][WORD_BITS-1:0] dsr_r, dsr_nxt;
  logic [WIDE-1:0]                 rem_r, rem_nxt;
  logic [WIDE-1:0]                 quo_r, quo_nxt;
  logic [WIDE:0]                   shifted;
  logic [WIDE+1:0]                 trial;

  assign shifted = {rem_r, dvd_r[cmd.bit_idx[IDX_W-1:SHIFT]][cmd.bit_idx[SHIFT-1:0]]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.load) begin
      if (cmd.load_first) begin
        dvd_nxt = '0;
        dsr_nxt = '0;
      end
      dvd_nxt[cmd.load_idx] = dividend_word;
      dsr_nxt[cmd.load_idx] = divisor_word;
    end
    if (cmd.prep) begin
      rem_nxt = '0;
      quo_nxt = '0;
    end
    if (cmd.step) begin
      rem_nxt = trial[WIDE+1] ? shifted[WIDE-1:0] : trial[WIDE-1:0];
      quo_nxt = {quo_r[WIDE-2:0], ~trial[WIDE+1]};
    end
    if (cmd.emit) begin
      rem_nxt = rem_r >> WORD_BITS;
      quo_nxt = quo_r >> WORD_BITS;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign divisor_zero = (dsr_r == '0);
  assign quo_word     = quo_r[WORD_BITS-1:0];
  assign rem_word     = rem_r[WORD_BITS-1:0];

endmodule
`default_nettype wire

/* sv/wide_restoring_divider.sv */
// Top level of the wide unsigned restoring divider.
//
// Load operands with start while busy is low: each beat carries one 32-bit
// word of dividend and divisor, lowest word first; in_last_word closes both
// operands. Up to 6 words are stored; data of further words is dropped.
// After the last beat busy rises: the setup state, then the shift-subtract
// cycles (n = words loaded), one quotient bit each through a 194-bit
// subtractor, then n result beats on consecutive cycles marked by
// out_strobe, lowest word first, out_final_result on the last one.
// A zero divisor skips the shift-subtract cycles and gives n zero words
// with out_zero_divisor set. The receiver takes every result beat; there
// is no stall path. Synchronous reset drops any operation in progress and
// clears the word count; the operand registers hold no reset value.
`default_nettype none
module wide_restoring_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] in_dividend_word,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] in_divisor_word,
  input  logic                            in_last_word,
  output logic                            out_strobe,
  output logic [wrdiv_pkg::WORD_BITS-1:0] out_quotient_word,
  output logic [wrdiv_pkg::WORD_BITS-1:0] out_remainder_word,
  output logic                            out_final_result,
  output logic                            out_zero_divisor
);
  import wrdiv_pkg::*;

  dp_cmd_t              cmd;
  out_stat_t            ostat;
  logic                 divisor_zero;
  logic [WORD_BITS-1:0] quo_word;
  logic [WORD_BITS-1:0] rem_word;

  wrdiv_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .last_word    (in_last_word),
    .divisor_zero (divisor_zero),
    .busy         (busy),
    .cmd          (cmd),
    .ostat        (ostat)
  );

  wrdiv_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .dividend_word (in_dividend_word),
    .divisor_word  (in_divisor_word),
    .divisor_zero  (divisor_zero),
    .quo_word      (quo_word),
    .rem_word      (rem_word)
  );

  assign out_strobe         = ostat.strobe;
  assign out_final_result   = ostat.fin;
  assign out_zero_divisor   = ostat.zero;
  assign out_quotient_word  = ostat.zero ? '0 : quo_word;
  assign out_remainder_word = ostat.zero ? '0 : rem_word;

endmodule
`default_nettype wire

/* sv/wrdiv_chk.sv */
// Port-level checker for the wide restoring divider, bound to the top level.
`default_nettype none
module wrdiv_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [wrdiv_pkg::WORD_BITS-1:0] out_quotient_word,
  input logic [wrdiv_pkg::WORD_BITS-1:0] out_remainder_word,
  input logic                            out_final_result,
  input logic                            out_zero_divisor
);
  import wrdiv_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");

  a_zero_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_divisor) |->
      (out_quotient_word == '0 && out_remainder_word == '0))
    else $error("nonzero words on zero divisor");

  a_final_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_result |-> out_strobe)
    else $error("final marker outside a beat");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_final_result) |=> (!out_strobe && !busy))
    else $error("beats continue after final word");

endmodule

bind wide_restoring_divider wrdiv_chk u_wrdiv_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_quotient_word  (out_quotient_word),
  .out_remainder_word (out_remainder_word),
  .out_final_result   (out_final_result),
  .out_zero_divisor   (out_zero_divisor)
);
`default_nettype wire

/* dv/wrdiv_checker.sv */
// Checker for the wide restoring divider: predicts quotient and remainder beats and compares them.
module wrdiv_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] in_dividend_word,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] in_divisor_word,
  input  logic                            in_last_word,
  input  logic                            out_strobe,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] out_quotient_word,
  input  logic [wrdiv_pkg::WORD_BITS-1:0] out_remainder_word,
  input  logic                            out_final_result,
  input  logic                            out_zero_divisor,
  output int                              errors,
  output int                              pending,
  output int                              results_seen
);
  import wrdiv_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] rem;
    logic                 fin;
    logic                 zero;
  } div_word_t;

  div_word_t            quot_rem_q[$];
  logic [WORD_BITS-1:0] dvd_buf[WORDS];
  logic [WORD_BITS-1:0] dvs_buf[WORDS];
  int unsigned          words_held;
  int                   err_count;
  int                   beats_checked;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    err_count = 0;
    beats_checked = 0;
    words_held = 0;
  end

  task automatic predict_division(input int unsigned n);
    logic [WIDE-1:0] num;
    logic [WIDE-1:0] den;
    logic [WIDE-1:0] quo;
    logic [WIDE-1:0] rem;
    div_word_t       w;
    num = '0;
    den = '0;
    for (int k = 0; k < n; k++) begin
      num[k*WORD_BITS +: WORD_BITS] = dvd_buf[k];
      den[k*WORD_BITS +: WORD_BITS] = dvs_buf[k];
    end
    if (den == '0) begin
      quo = '0;
      rem = '0;
    end else begin
      quo = num / den;
      rem = num % den;
    end
    for (int k = 0; k < n; k++) begin
      w.quo = quo[k*WORD_BITS +: WORD_BITS];
      w.rem = rem[k*WORD_BITS +: WORD_BITS];
      w.fin = (k == n - 1);
      w.zero = (den == '0);
      quot_rem_q.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                             input logic [WORD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    div_word_t want;
    if (!rst_n) begin
      words_held = 0;
    end else begin
      if (out_strobe) begin
        beats_checked++;
        if (quot_rem_q.size() == 0) begin
          $error("result beat with nothing expected: quotient_word %h remainder_word %h",
                 out_quotient_word, out_remainder_word);
          err_count++;
        end else begin
          want = quot_rem_q.pop_front();
          check_field("quotient_word", want.quo, out_quotient_word);
          check_field("remainder_word", want.rem, out_remainder_word);
          check_field("final_result", want.fin, out_final_result);
          check_field("zero_divisor", want.zero, out_zero_divisor);
        end
      end
      if (start && !busy) begin
        if (words_held < WORDS) begin
          dvd_buf[words_held] = in_dividend_word;
          dvs_buf[words_held] = in_divisor_word;
          words_held++;
        end
        if (in_last_word) begin
          predict_division(words_held);
          words_held = 0;
        end
      end
    end
    errors <= err_count;
    pending <= quot_rem_q.size();
    results_seen <= beats_checked;
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the wide restoring divider: operand stimulus, timeout and verdict.
module tb_top;
  import wrdiv_pkg::*;

  localparam int MAX_BEATS    = 8;
  localparam int RANDOM_BEATS = 420;
  localparam int DRAIN_CYCLES = WORDS * 33 + 10;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [WORD_BITS-1:0] in_dividend_word;
  logic [WORD_BITS-1:0] in_divisor_word;
  logic                 in_last_word;
  logic                 out_strobe;
  logic [WORD_BITS-1:0] out_quotient_word;
  logic [WORD_BITS-1:0] out_remainder_word;
  logic                 out_final_result;
  logic                 out_zero_divisor;
  int                   errors;
  int                   pending;
  int                   results_seen;

  logic [WORD_BITS-1:0] op_dvd[MAX_BEATS];
  logic [WORD_BITS-1:0] op_dvs[MAX_BEATS];
  bit                   gaps_on;
  int                   beats_sent;
  int                   ops_sent;
  int                   zero_div_ops;
  int                   long_ops;

  wide_restoring_divider i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_dividend_word   (in_dividend_word),
    .in_divisor_word    (in_divisor_word),
    .in_last_word       (in_last_word),
    .out_strobe         (out_strobe),
    .out_quotient_word  (out_quotient_word),
    .out_remainder_word (out_remainder_word),
    .out_final_result   (out_final_result),
    .out_zero_divisor   (out_zero_divisor)
  );

  wrdiv_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_dividend_word   (in_dividend_word),
    .in_divisor_word    (in_divisor_word),
    .in_last_word       (in_last_word),
    .out_strobe         (out_strobe),
    .out_quotient_word  (out_quotient_word),
    .out_remainder_word (out_remainder_word),
    .out_final_result   (out_final_result),
    .out_zero_divisor   (out_zero_divisor),
    .errors             (errors),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return WORD_BITS'($urandom_range(0, 255));
      3: return WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_operation(input int n);
    bit zero_div;
    zero_div = 1'b1;
    for (int k = 0; k < n && k < WORDS; k++) begin
      if (op_dvs[k] != '0) zero_div = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      maybe_idle();
      start <= 1'b1;
      in_dividend_word <= op_dvd[k];
      in_divisor_word <= op_dvs[k];
      in_last_word <= (k == n - 1);
      @(posedge clk);
      while (busy) @(posedge clk);
      beats_sent++;
    end
    ops_sent++;
    if (zero_div) zero_div_ops++;
    if (n > WORDS) long_ops++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic build_random_operation(output int n);
    int m;
    int eff;
    n = ($urandom_range(0, 15) < 14) ? $urandom_range(1, WORDS) : $urandom_range(7, MAX_BEATS);
    eff = (n < WORDS) ? n : WORDS;
    m = $urandom_range(1, eff);
    for (int k = 0; k < MAX_BEATS; k++) begin
      op_dvd[k] = rand_word();
      op_dvs[k] = (k < m || k >= WORDS) ? rand_word() : '0;
    end
    case ($urandom_range(0, 15))
      0: for (int k = 0; k < WORDS; k++) op_dvs[k] = '0;
      1: for (int k = 0; k < MAX_BEATS; k++) op_dvs[k] = op_dvd[k];
      2: for (int k = 0; k < MAX_BEATS; k++) op_dvd[k] = WORD_BITS'($urandom);
      default: ;
    endcase
  endtask

  initial begin
    int n;
    bit drained;
    start <= 1'b0;
    rst_n <= 1'b0;
    in_dividend_word <= '0;
    in_divisor_word <= '0;
    in_last_word <= 1'b0;
    beats_sent = 0;
    ops_sent = 0;
    zero_div_ops = 0;
    long_ops = 0;
    gaps_on = 1'b1;
    drained = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    op_dvd[0] = '1;
    op_dvs[0] = 32'd1;
    send_operation(1);
    op_dvd[0] = '0;
    op_dvs[0] = 32'd5;
    send_operation(1);
    op_dvd[0] = 32'd7;
    op_dvd[1] = 32'h8000_0000;
    op_dvs[0] = '0;
    op_dvs[1] = '0;
    send_operation(2);
    op_dvd[0] = 32'd5;
    op_dvd[1] = '0;
    op_dvs[0] = '0;
    op_dvs[1] = 32'd1;
    send_operation(2);
    for (int k = 0; k < WORDS; k++) begin
      op_dvd[k] = '1;
      op_dvs[k] = (k == 0) ? 32'd1 : '0;
    end
    send_operation(WORDS);
    for (int k = 0; k < WORDS; k++) op_dvs[k] = '1;
    send_operation(WORDS);
    for (int k = 0; k < 7; k++) begin
      op_dvd[k] = (k < WORDS) ? WORD_BITS'($urandom) : '1;
      op_dvs[k] = (k < 2 || k >= WORDS) ? WORD_BITS'($urandom) : '0;
    end
    send_operation(7);
    wait_all_results();

    n = beats_sent;
    while (beats_sent < n + RANDOM_BEATS) begin
      gaps_on = (beats_sent < n + RANDOM_BEATS - 60) && ($urandom_range(0, 3) != 0);
      if (!drained && beats_sent >= n + RANDOM_BEATS / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      begin : one_op
        int len;
        build_random_operation(len);
        send_operation(len);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d divisions over %0d operand beats: %0d zero divisor, %0d overlong.",
             ops_sent, beats_sent, zero_div_ops, long_ops);
    $display("Checked %0d result beats, operands of 1 to %0d words.", results_seen, MAX_BEATS);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
